// ----- hw/rtl/glzw_pkg.sv -----
// ============================================================================
// GIF LZW decoder package
// Shared constants and types for the GIF LZW decoder modules.
// ============================================================================
`default_nettype none

package glzw_pkg;

    // Width of a string length and of the per-request output byte count.
    localparam int LW        = 13;
    // Decoded bytes one request may produce, and the address width into them.
    localparam int OUT_CAP   = 4096;
    localparam int OB_AW     = 12;
    // Bytes carried by one result, with its index width and count width.
    localparam int RES_BYTES = 64;
    localparam int RES_AW    = 6;
    localparam int CNT_W     = 7;

    // Result status codes.
    localparam logic [1:0] ST_DATA = 2'd0;
    localparam logic [1:0] ST_END  = 2'd1;
    localparam logic [1:0] ST_ERR  = 2'd2;

    // One byte write into the output byte buffer.
    typedef struct packed {
        logic             en;
        logic [OB_AW-1:0] addr;
        logic [7:0]       data;
    } obuf_wr_t;

    // Command that hands the buffered bytes of one request to the emitter.
    typedef struct packed {
        logic          start;
        logic          err;
        logic [1:0]    status;
        logic [LW-1:0] total;
    } emit_cmd_t;

endpackage : glzw_pkg

`default_nettype wire

// ----- hw/rtl/glzw_unpack.sv -----
// ============================================================================
// GIF LZW bit unpacker
// Collects compressed bytes and peels variable-width codes, LSB first.
// ============================================================================
`default_nettype none

module glzw_unpack
    import glzw_pkg::*;
#(
    parameter int CODE_BITS = 12
)
(
    input  wire logic                             clk,
    input  wire logic                             rst_n,
    input  wire logic                             clear,
    input  wire logic                             load,
    input  wire logic [7:0]                       load_byte,
    input  wire logic                             consume,
    input  wire logic [3:0]                       width,
    output logic      [CODE_BITS-1:0]             code,
    output logic      [$clog2(CODE_BITS+9)-1:0]   count
);

    localparam int SW  = CODE_BITS + 8;
    localparam int BCW = $clog2(CODE_BITS + 9);

    logic [SW-1:0]  store_reg;
    logic [SW-1:0]  store_next;
    logic [BCW-1:0] count_reg;
    logic [BCW-1:0] count_next;

    always_comb
    begin
        store_next = store_reg;
        count_next = count_reg;
        if (clear)
        begin
            store_next = '0;
            count_next = '0;
        end
        else if (load)
        begin
            store_next = store_reg | (SW'(load_byte) << count_reg);
            count_next = count_reg + BCW'(8);
        end
        else if (consume)
        begin
            store_next = store_reg >> width;
            count_next = count_reg - BCW'(width);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            store_reg <= '0;
            count_reg <= '0;
        end
        else
        begin
            store_reg <= store_next;
            count_reg <= count_next;
        end
    end

    assign code  = store_reg[CODE_BITS-1:0] & ~({CODE_BITS{1'b1}} << width);
    assign count = count_reg;

endmodule : glzw_unpack

`default_nettype wire

// ----- hw/rtl/glzw_emit.sv -----
// ============================================================================
// GIF LZW result emitter
// Holds the decoded bytes of one request and packs them into results.
// ============================================================================
`default_nettype none

module glzw_emit
    import glzw_pkg::*;
(
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire emit_cmd_t        cmd,
    input  wire obuf_wr_t         wr,
    output logic                  done,
    output logic                  out_valid,
    input  wire logic             out_stall,
    output logic      [63:0]      bytes_0_7,
    output logic      [63:0]      bytes_8_15,
    output logic      [63:0]      bytes_16_23,
    output logic      [63:0]      bytes_24_31,
    output logic      [63:0]      bytes_32_39,
    output logic      [63:0]      bytes_40_47,
    output logic      [63:0]      bytes_48_55,
    output logic      [63:0]      bytes_56_63,
    output logic      [CNT_W-1:0] byte_count,
    output logic                  last,
    output logic      [1:0]       status
);

    localparam logic [1:0] E_IDLE   = 2'd0;
    localparam logic [1:0] E_GATHER = 2'd1;
    localparam logic [1:0] E_HOLD   = 2'd2;

    logic [7:0] obuf_mem [OUT_CAP];
    logic [7:0] obuf_rd_reg;

    logic [1:0]                   est_reg, est_next;
    logic [LW-1:0]                total_reg, total_next;
    logic [1:0]                   stat_reg, stat_next;
    logic [LW-1:0]                rd_reg, rd_next;
    logic [LW-1:0]                end_reg, end_next;
    logic                         pend_reg, pend_next;
    logic [RES_AW-1:0]            ppos_reg, ppos_next;
    logic [CNT_W-1:0]             cnt_reg, cnt_next;
    logic                         last_reg, last_next;
    logic [1:0]                   ostat_reg, ostat_next;
    logic [RES_BYTES-1:0][7:0]    asm_reg;
    logic                         asm_clr;
    logic                         issue;
    logic [LW:0]                  res_sum;
    logic [LW-1:0]                res_end;
    logic                         accept;

    assign accept = (est_reg == E_HOLD) && !out_stall;

    // End of the result that starts at the current read index.
    always_comb
    begin
        res_sum = {1'b0, rd_reg} + (LW+1)'(RES_BYTES);
        if (res_sum > {1'b0, total_reg})
        begin
            res_end = total_reg;
        end
        else
        begin
            res_end = res_sum[LW-1:0];
        end
    end

    assign issue = (est_reg == E_GATHER) && (rd_reg < end_reg);

    always_comb
    begin
        est_next   = est_reg;
        total_next = total_reg;
        stat_next  = stat_reg;
        rd_next    = rd_reg;
        end_next   = end_reg;
        pend_next  = 1'b0;
        ppos_next  = ppos_reg;
        cnt_next   = cnt_reg;
        last_next  = last_reg;
        ostat_next = ostat_reg;
        asm_clr    = 1'b0;
        done       = 1'b0;
        unique case (est_reg)
            E_IDLE:
            begin
                if (cmd.start)
                begin
                    asm_clr  = 1'b1;
                    cnt_next = '0;
                    if (cmd.err)
                    begin
                        last_next  = 1'b1;
                        ostat_next = ST_ERR;
                        est_next   = E_HOLD;
                    end
                    else
                    begin
                        total_next = cmd.total;
                        stat_next  = cmd.status;
                        rd_next    = '0;
                        end_next   = (cmd.total > LW'(RES_BYTES)) ? LW'(RES_BYTES) : cmd.total;
                        est_next   = E_GATHER;
                    end
                end
            end
            E_GATHER:
            begin
                if (issue)
                begin
                    rd_next   = rd_reg + LW'(1);
                    pend_next = 1'b1;
                    ppos_next = rd_reg[RES_AW-1:0];
                end
                if (pend_reg)
                begin
                    cnt_next = cnt_reg + CNT_W'(1);
                end
                if (!issue && !pend_reg)
                begin
                    last_next  = (end_reg == total_reg);
                    ostat_next = (end_reg == total_reg) ? stat_reg : ST_DATA;
                    est_next   = E_HOLD;
                end
            end
            E_HOLD:
            begin
                if (accept)
                begin
                    if (last_reg)
                    begin
                        done     = 1'b1;
                        est_next = E_IDLE;
                    end
                    else
                    begin
                        asm_clr  = 1'b1;
                        cnt_next = '0;
                        end_next = res_end;
                        est_next = E_GATHER;
                    end
                end
            end
            default:
            begin
                est_next = E_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            est_reg   <= E_IDLE;
            total_reg <= '0;
            stat_reg  <= ST_DATA;
            rd_reg    <= '0;
            end_reg   <= '0;
            pend_reg  <= 1'b0;
            ppos_reg  <= '0;
            cnt_reg   <= '0;
            last_reg  <= 1'b0;
            ostat_reg <= ST_DATA;
        end
        else
        begin
            est_reg   <= est_next;
            total_reg <= total_next;
            stat_reg  <= stat_next;
            rd_reg    <= rd_next;
            end_reg   <= end_next;
            pend_reg  <= pend_next;
            ppos_reg  <= ppos_next;
            cnt_reg   <= cnt_next;
            last_reg  <= last_next;
            ostat_reg <= ostat_next;
        end
    end

    // Output byte buffer: one write port from the decoder, one read port here.
    always_ff @(posedge clk)
    begin
        if (wr.en)
        begin
            obuf_mem[wr.addr] <= wr.data;
        end
        if (issue)
        begin
            obuf_rd_reg <= obuf_mem[rd_reg[OB_AW-1:0]];
        end
    end

    always_ff @(posedge clk)
    begin
        if (asm_clr)
        begin
            asm_reg <= '0;
        end
        else if (pend_reg)
        begin
            asm_reg[ppos_reg] <= obuf_rd_reg;
        end
    end

    assign out_valid   = (est_reg == E_HOLD);
    assign bytes_0_7   = asm_reg[7:0];
    assign bytes_8_15  = asm_reg[15:8];
    assign bytes_16_23 = asm_reg[23:16];
    assign bytes_24_31 = asm_reg[31:24];
    assign bytes_32_39 = asm_reg[39:32];
    assign bytes_40_47 = asm_reg[47:40];
    assign bytes_48_55 = asm_reg[55:48];
    assign bytes_56_63 = asm_reg[63:56];
    assign byte_count  = cnt_reg;
    assign last        = last_reg;
    assign status      = ostat_reg;

endmodule : glzw_emit

`default_nettype wire

// ----- hw/rtl/gif_lzw_decoder_top.sv -----
// ============================================================================
// GIF LZW decoder
// Variable-width LZW decompressor for GIF image data, one byte per request.
// ============================================================================
// Usage:
//   The input channel (in_valid, in_stall, data_byte) takes one compressed
//   byte per request. The output channel (out_valid, out_stall, bytes_*,
//   byte_count, last, status) returns up to 64 decoded bytes per result,
//   with last set on the final result caused by an input byte. A byte that
//   decodes no bytes and hits no end code or error gives no result at all.
//   The root_bits register is written through cfg_wr_en while the block is
//   idle, and input requests stall during the write. A write restarts the
//   decoder with an empty bit store, a fresh table and cleared flags.
//   Sequence: an input request loads its byte, then each code takes a decode
//   step, a walk step per string byte beyond the first (one table read
//   each, on the single table read port), a leaf step and a commit step; a
//   clear code takes its decode step only. A request ends in a finish step
//   (too few bits or the end code) or an error step (an invalid code or a
//   string that does not fit). Each result then reads its bytes back from
//   the output buffer one at a time and holds while the receiver stalls.
//   in_stall stays high the whole time, so requests are handled one at a time.
//   After reset root_bits is 8 and the decoder is ready at once. After an end
//   code or an error, bytes are taken and dropped until the next write.
// ============================================================================
`default_nettype none

module gif_lzw_decoder_top
    import glzw_pkg::*;
#(
    parameter int TABLE_ENTRIES = 4096,
    parameter int STRING_DEPTH  = 4096,
    parameter int MAX_CODE_BITS = 12
)
(
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             cfg_wr_en,
    input  wire logic [3:0]       root_bits,
    input  wire logic             in_valid,
    output logic                  in_stall,
    input  wire logic [7:0]       data_byte,
    output logic                  out_valid,
    input  wire logic             out_stall,
    output logic      [63:0]      bytes_0_7,
    output logic      [63:0]      bytes_8_15,
    output logic      [63:0]      bytes_16_23,
    output logic      [63:0]      bytes_24_31,
    output logic      [63:0]      bytes_32_39,
    output logic      [63:0]      bytes_40_47,
    output logic      [63:0]      bytes_48_55,
    output logic      [63:0]      bytes_56_63,
    output logic      [CNT_W-1:0] byte_count,
    output logic                  last,
    output logic      [1:0]       status
);

    localparam int CW  = MAX_CODE_BITS;
    localparam int NW  = $clog2(TABLE_ENTRIES + 1);
    localparam int TW  = $clog2(TABLE_ENTRIES);
    localparam int KW  = ((NW > CW) ? NW : CW) + 1;
    localparam int EW  = CW + 8 + LW;
    localparam int BCW = $clog2(CW + 9);

    // Sequencer states.
    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_DECODE = 3'd1;
    localparam logic [2:0] S_WALK   = 3'd2;
    localparam logic [2:0] S_LEAF   = 3'd3;
    localparam logic [2:0] S_COMMIT = 3'd4;
    localparam logic [2:0] S_FINISH = 3'd5;
    localparam logic [2:0] S_ERROR  = 3'd6;
    localparam logic [2:0] S_EMIT   = 3'd7;

    // String table. Each entry holds the prefix code, the final byte and the
    // string length, so a string is written straight into its final place in
    // the output buffer while the prefix chain is walked from its tail.
    logic [EW-1:0] tbl_mem [TABLE_ENTRIES];
    logic [EW-1:0] tbl_rd_reg;
    logic          tbl_re;
    logic [TW-1:0] tbl_raddr;
    logic          tbl_we;
    logic [TW-1:0] tbl_waddr;
    logic [EW-1:0] tbl_wdata;

    logic [2:0]    state_reg, state_next;
    logic [3:0]    min_reg, min_next;
    logic [NW-1:0] nf_reg, nf_next;
    logic [3:0]    width_reg, width_next;
    logic [CW-1:0] prev_reg, prev_next;
    logic [LW-1:0] prev_len_reg, prev_len_next;
    logic          pv_reg, pv_next;
    logic          fin_reg, fin_next;
    logic          err_reg, err_next;
    logic [LW-1:0] out_len_reg, out_len_next;
    logic [1:0]    status_reg, status_next;
    logic [CW-1:0] code_reg, code_next;
    logic          kwk_reg, kwk_next;
    logic [LW-1:0] str_len_reg, str_len_next;
    logic [LW-1:0] pos_reg, pos_next;
    logic [7:0]    leaf_reg, leaf_next;
    logic          first_reg, first_next;

    logic           unp_clear;
    logic           unp_load;
    logic           unp_consume;
    logic [CW-1:0]  unp_code;
    logic [BCW-1:0] unp_count;

    obuf_wr_t  obuf_wr;
    emit_cmd_t emit_cmd;
    logic      emit_done;

    logic [3:0]    cfg_min;
    logic [CW-1:0] roots;
    logic [CW-1:0] cfg_roots;
    logic [KW-1:0] code_k;
    logic [KW-1:0] nf_k;
    logic          kwk_c;
    logic [CW-1:0] walk_code;
    logic [CW-1:0] e_prefix;
    logic [7:0]    e_suffix;
    logic [LW-1:0] e_len;
    logic [LW-1:0] len_sel;
    logic [LW:0]   need;
    logic [LW-1:0] wpos;
    logic [NW-1:0] nf_inc;

    glzw_unpack #(
        .CODE_BITS (CW)
    ) u_unpack (
        .clk       (clk),
        .rst_n     (rst_n),
        .clear     (unp_clear),
        .load      (unp_load),
        .load_byte (data_byte),
        .consume   (unp_consume),
        .width     (width_reg),
        .code      (unp_code),
        .count     (unp_count)
    );

    glzw_emit u_emit (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (emit_cmd),
        .wr          (obuf_wr),
        .done        (emit_done),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .bytes_0_7   (bytes_0_7),
        .bytes_8_15  (bytes_8_15),
        .bytes_16_23 (bytes_16_23),
        .bytes_24_31 (bytes_24_31),
        .bytes_32_39 (bytes_32_39),
        .bytes_40_47 (bytes_40_47),
        .bytes_48_55 (bytes_48_55),
        .bytes_56_63 (bytes_56_63),
        .byte_count  (byte_count),
        .last        (last),
        .status      (status)
    );

    // Register values outside 2..8 are clamped into that range.
    always_comb
    begin
        if (root_bits < 4'd2)
        begin
            cfg_min = 4'd2;
        end
        else if (root_bits > 4'd8)
        begin
            cfg_min = 4'd8;
        end
        else
        begin
            cfg_min = root_bits;
        end
    end

    assign roots     = CW'(1) << min_reg;
    assign cfg_roots = CW'(1) << cfg_min;
    assign code_k    = KW'(unp_code);
    assign nf_k      = KW'(nf_reg);
    // A code equal to the next free code expands the previous string again.
    assign kwk_c     = pv_reg && (code_k == nf_k);
    assign walk_code = kwk_c ? prev_reg : unp_code;

    assign e_prefix = tbl_rd_reg[EW-1 -: CW];
    assign e_suffix = tbl_rd_reg[LW +: 8];
    assign e_len    = tbl_rd_reg[LW-1:0];
    assign nf_inc   = nf_reg + NW'(1);

    // A register write takes the idle cycle, so no input request is taken
    // at the same edge.
    assign in_stall = (state_reg != S_IDLE) || cfg_wr_en;

    always_comb
    begin
        state_next    = state_reg;
        min_next      = min_reg;
        nf_next       = nf_reg;
        width_next    = width_reg;
        prev_next     = prev_reg;
        prev_len_next = prev_len_reg;
        pv_next       = pv_reg;
        fin_next      = fin_reg;
        err_next      = err_reg;
        out_len_next  = out_len_reg;
        status_next   = status_reg;
        code_next     = code_reg;
        kwk_next      = kwk_reg;
        str_len_next  = str_len_reg;
        pos_next      = pos_reg;
        leaf_next     = leaf_reg;
        first_next    = first_reg;
        tbl_re        = 1'b0;
        tbl_raddr     = '0;
        tbl_we        = 1'b0;
        tbl_waddr     = '0;
        tbl_wdata     = '0;
        unp_clear     = 1'b0;
        unp_load      = 1'b0;
        unp_consume   = 1'b0;
        obuf_wr       = '0;
        emit_cmd      = '0;
        len_sel       = e_len;
        need          = '0;
        wpos          = pos_reg;

        unique case (state_reg)
            S_IDLE:
            begin
                if (cfg_wr_en)
                begin
                    min_next   = cfg_min;
                    nf_next    = NW'(cfg_roots) + NW'(2);
                    width_next = cfg_min + 4'd1;
                    prev_next  = '0;
                    pv_next    = 1'b0;
                    fin_next   = 1'b0;
                    err_next   = 1'b0;
                    unp_clear  = 1'b1;
                end
                else if (in_valid && !fin_reg && !err_reg)
                begin
                    unp_load     = 1'b1;
                    out_len_next = '0;
                    status_next  = ST_DATA;
                    state_next   = S_DECODE;
                end
            end

            S_DECODE:
            begin
                if (unp_count < BCW'(width_reg))
                begin
                    state_next = S_FINISH;
                end
                else
                begin
                    unp_consume = 1'b1;
                    priority if (unp_code == roots)
                    begin
                        // Clear code: fresh table, no previous code.
                        nf_next    = NW'(roots) + NW'(2);
                        width_next = min_reg + 4'd1;
                        prev_next  = '0;
                        pv_next    = 1'b0;
                    end
                    else if (unp_code == roots + CW'(1))
                    begin
                        fin_next    = 1'b1;
                        status_next = ST_END;
                        state_next  = S_FINISH;
                    end
                    else if ((code_k >= KW'(TABLE_ENTRIES)) ||
                             (!pv_reg && (code_k >= nf_k)) ||
                             (pv_reg && (code_k > nf_k)))
                    begin
                        state_next = S_ERROR;
                    end
                    else
                    begin
                        code_next = unp_code;
                        kwk_next  = kwk_c;
                        if (walk_code < roots)
                        begin
                            // A root string is a single byte: no table read.
                            need = {1'b0, out_len_reg} + (LW+1)'(1) + (LW+1)'(kwk_c);
                            leaf_next    = walk_code[7:0];
                            pos_next     = out_len_reg;
                            str_len_next = LW'(1) + LW'(kwk_c);
                            if (need > (LW+1)'(OUT_CAP))
                            begin
                                state_next = S_ERROR;
                            end
                            else
                            begin
                                state_next = S_LEAF;
                            end
                        end
                        else
                        begin
                            tbl_re     = 1'b1;
                            tbl_raddr  = TW'(walk_code);
                            first_next = 1'b1;
                            state_next = S_WALK;
                        end
                    end
                end
            end

            S_WALK:
            begin
                // One table entry per cycle, tail byte first.
                len_sel = e_len;
                need    = {1'b0, out_len_reg} + {1'b0, len_sel} + (LW+1)'(kwk_reg);
                if (first_reg)
                begin
                    wpos         = out_len_reg + len_sel - LW'(1);
                    str_len_next = len_sel + LW'(kwk_reg);
                end
                first_next = 1'b0;
                if (first_reg && ((len_sel > LW'(STRING_DEPTH)) ||
                                  (need > (LW+1)'(OUT_CAP))))
                begin
                    state_next = S_ERROR;
                end
                else
                begin
                    obuf_wr.en   = 1'b1;
                    obuf_wr.addr = wpos[OB_AW-1:0];
                    obuf_wr.data = e_suffix;
                    pos_next     = wpos - LW'(1);
                    if (e_prefix >= roots)
                    begin
                        tbl_re    = 1'b1;
                        tbl_raddr = TW'(e_prefix);
                    end
                    else
                    begin
                        leaf_next  = e_prefix[7:0];
                        state_next = S_LEAF;
                    end
                end
            end

            S_LEAF:
            begin
                obuf_wr.en   = 1'b1;
                obuf_wr.addr = pos_reg[OB_AW-1:0];
                obuf_wr.data = leaf_reg;
                state_next   = S_COMMIT;
            end

            S_COMMIT:
            begin
                if (kwk_reg)
                begin
                    wpos         = out_len_reg + str_len_reg - LW'(1);
                    obuf_wr.en   = 1'b1;
                    obuf_wr.addr = wpos[OB_AW-1:0];
                    obuf_wr.data = leaf_reg;
                end
                if (pv_reg && (nf_k < KW'(TABLE_ENTRIES)))
                begin
                    tbl_we    = 1'b1;
                    tbl_waddr = TW'(nf_reg);
                    tbl_wdata = {prev_reg, leaf_reg, prev_len_reg + LW'(1)};
                    nf_next   = nf_inc;
                    if ((KW'(nf_inc) >= (KW'(1) << width_reg)) &&
                        (width_reg < 4'(MAX_CODE_BITS)))
                    begin
                        width_next = width_reg + 4'd1;
                    end
                end
                prev_next     = code_reg;
                prev_len_next = str_len_reg;
                pv_next       = 1'b1;
                out_len_next  = out_len_reg + str_len_reg;
                state_next    = S_DECODE;
            end

            S_FINISH:
            begin
                if ((out_len_reg == '0) && (status_reg == ST_DATA))
                begin
                    state_next = S_IDLE;
                end
                else
                begin
                    emit_cmd.start  = 1'b1;
                    emit_cmd.status = status_reg;
                    emit_cmd.total  = out_len_reg;
                    state_next      = S_EMIT;
                end
            end

            S_ERROR:
            begin
                err_next       = 1'b1;
                emit_cmd.start = 1'b1;
                emit_cmd.err   = 1'b1;
                state_next     = S_EMIT;
            end

            S_EMIT:
            begin
                if (emit_done)
                begin
                    state_next = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= S_IDLE;
            min_reg      <= 4'd8;
            nf_reg       <= NW'(258);
            width_reg    <= 4'd9;
            prev_reg     <= '0;
            prev_len_reg <= '0;
            pv_reg       <= 1'b0;
            fin_reg      <= 1'b0;
            err_reg      <= 1'b0;
            out_len_reg  <= '0;
            status_reg   <= ST_DATA;
            code_reg     <= '0;
            kwk_reg      <= 1'b0;
            str_len_reg  <= '0;
            pos_reg      <= '0;
            leaf_reg     <= '0;
            first_reg    <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            min_reg      <= min_next;
            nf_reg       <= nf_next;
            width_reg    <= width_next;
            prev_reg     <= prev_next;
            prev_len_reg <= prev_len_next;
            pv_reg       <= pv_next;
            fin_reg      <= fin_next;
            err_reg      <= err_next;
            out_len_reg  <= out_len_next;
            status_reg   <= status_next;
            code_reg     <= code_next;
            kwk_reg      <= kwk_next;
            str_len_reg  <= str_len_next;
            pos_reg      <= pos_next;
            leaf_reg     <= leaf_next;
            first_reg    <= first_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (tbl_we)
        begin
            tbl_mem[tbl_waddr] <= tbl_wdata;
        end
        if (tbl_re)
        begin
            tbl_rd_reg <= tbl_mem[tbl_raddr];
        end
    end

    // Results only appear while the sequencer hands its bytes to the emitter.
    a_out_in_emit: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (state_reg == S_EMIT))
        else $error("result presented outside the emit phase");

    // The code width never grows past its maximum.
    a_width_max: assert property (@(posedge clk) disable iff (!rst_n)
        width_reg <= 4'(MAX_CODE_BITS))
        else $error("code width above maximum");

    // A register write leaves the decoder restarted and free of flags.
    a_cfg_restart: assert property (@(posedge clk) disable iff (!rst_n)
        (cfg_wr_en && (state_reg == S_IDLE)) |=> (!pv_reg && !fin_reg && !err_reg))
        else $error("register write did not restart the decoder");

    // The buffered byte count never exceeds the buffer.
    a_out_len: assert property (@(posedge clk) disable iff (!rst_n)
        out_len_reg <= LW'(OUT_CAP))
        else $error("output byte count beyond buffer");

endmodule : gif_lzw_decoder_top

`default_nettype wire
